// ===== hw/rtl/rectilinear_polygon_query_defines.svh =====
// Assertion macros for the rectilinear polygon query block.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef RECTILINEAR_POLYGON_QUERY_DEFINES_SVH
`define RECTILINEAR_POLYGON_QUERY_DEFINES_SVH

// same-cycle implication
`define RPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rpq_pkg.sv =====
// Shared types and codes for the rectilinear polygon query block.
// No dependencies; imported by every module of the block.
`default_nettype none

package rpq_pkg;

  localparam int unsigned COORD_W = 32;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_INSIDE = 2'd2,
    OP_RECT   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    op_e    operation;
    coord_t point_x;
    coord_t point_y;
  } rpq_in_t;

  typedef struct packed {
    status_e status;
    logic    inside_res;
    logic    found;
    coord_t  right_x;
    coord_t  up_y;
  } rpq_out_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

  typedef struct packed {
    logic start;
    logic rd_valid;
    logic rd_first;
    logic wrap;
  } rpq_eval_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rectilinear_polygon_query.sv =====
// Top level of the rectilinear polygon query block: control, count, result register.
// Depends on rpq_pkg, rpq_vstore and rpq_eval.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_ready_o  | in_item_i  (rpq_in_t)
//   out     | output    | out_valid_o/out_ready_i| out_item_o (rpq_out_t)
//
// Clear and append: the item moves to the done state, where the result is registered
// once the output slot is free. Queries scan n stored vertices, one vertex read per cycle
// from the single store read port, plus one edge for the wrap; an empty store goes
// straight to the done state. The next item can be taken once the result is registered.
// Reset clears the vertex count; store contents stay undefined until written.
// A waiting result does not block the next item; the next result waits for it.
`default_nettype none

module rectilinear_polygon_query #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rpq_pkg::rpq_in_t  in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rpq_pkg::rpq_out_t      out_item_o
);
  import rpq_pkg::*;

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_WRAP  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] addr_q, addr_d;
  logic          dv_q, dv_d, df_q, df_d;
  rpq_in_t       req_q;
  status_e       status_q, status_d;
  rpq_out_t      out_q, res;
  logic          out_valid_q;

  logic          accept, slot_free, is_query, last_issue, rd_en, we;
  vertex_t       wdata, rdata;
  rpq_eval_ctrl_t ectl;
  logic          parity, have_up, have_right, qok;
  coord_t        up_y, right_x;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign is_query   = (in_item_i.operation == OP_INSIDE) || (in_item_i.operation == OP_RECT);
  assign last_issue = (CW'(addr_q) == count_q - CW'(1));
  assign rd_en      = (state_q == S_SCAN);
  assign we         = accept && (in_item_i.operation == OP_APPEND) &&
                      (count_q != CW'(MAX_VERTICES));
  assign wdata      = '{x: in_item_i.point_x, y: in_item_i.point_y};

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    addr_d   = addr_q;
    status_d = status_q;
    dv_d     = rd_en;
    df_d     = rd_en && (addr_q == '0);
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d  = S_DONE;
          status_d = ST_OK;
          addr_d   = '0;
          case (in_item_i.operation)
            OP_CLEAR: begin
              count_d = '0;
            end
            OP_APPEND: begin
              if (count_q == CW'(MAX_VERTICES)) begin
                status_d = ST_FULL;
              end else begin
                count_d = count_q + CW'(1);
              end
            end
            default: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                state_d = S_SCAN;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        if (last_issue) begin
          state_d = S_DRAIN;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      S_DRAIN: state_d = S_WRAP;
      S_WRAP:  state_d = S_DONE;
      S_DONE: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      addr_q      <= '0;
      dv_q        <= 1'b0;
      df_q        <= 1'b0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      addr_q   <= addr_d;
      dv_q     <= dv_d;
      df_q     <= df_d;
      status_q <= status_d;
      if (state_q == S_DONE && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_item_i;
    end
    if (state_q == S_DONE && slot_free) begin
      out_q <= res;
    end
  end

  assign ectl = '{start:    accept && is_query && (count_q != '0),
                  rd_valid: dv_q,
                  rd_first: df_q,
                  wrap:     (state_q == S_WRAP)};

  rpq_vstore #(
    .DEPTH (MAX_VERTICES)
  ) u_vstore (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (wdata),
    .rd_en_i (rd_en),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  rpq_eval u_eval (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ectl),
    .px_i         (req_q.point_x),
    .py_i         (req_q.point_y),
    .vtx_i        (rdata),
    .parity_o     (parity),
    .have_up_o    (have_up),
    .have_right_o (have_right),
    .up_y_o       (up_y),
    .right_x_o    (right_x)
  );

  always_comb begin
    qok            = (status_q == ST_OK) &&
                     ((req_q.operation == OP_INSIDE) || (req_q.operation == OP_RECT));
    res.status     = status_q;
    res.inside_res = qok && (req_q.operation == OP_INSIDE) && parity;
    res.found      = qok && (req_q.operation == OP_RECT) && have_up && have_right;
    res.right_x    = (qok && (req_q.operation == OP_RECT) && have_right) ?
                     right_x : req_q.point_x;
    res.up_y       = (qok && (req_q.operation == OP_RECT) && have_up) ?
                     up_y : req_q.point_y;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rpq_vstore.sv =====
// Vertex store: one write port, one read port with registered read data.
// Depends on rpq_pkg for the vertex type.
`default_nettype none

module rpq_vstore #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire rpq_pkg::vertex_t wdata_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    raddr_i,
  output rpq_pkg::vertex_t      rdata_o
);
  import rpq_pkg::*;

  vertex_t mem_q [DEPTH];
  vertex_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rpq_eval.sv =====
// Scan datapath: edge crossing parity and nearest up/right neighbor search.
// Depends on rpq_pkg; fed one vertex per cycle from the vertex store.
`default_nettype none

module rpq_eval (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire rpq_pkg::rpq_eval_ctrl_t ctrl_i,
  input  wire rpq_pkg::coord_t         px_i,
  input  wire rpq_pkg::coord_t         py_i,
  input  wire rpq_pkg::vertex_t        vtx_i,
  output logic                         parity_o,
  output logic                         have_up_o,
  output logic                         have_right_o,
  output rpq_pkg::coord_t              up_y_o,
  output rpq_pkg::coord_t              right_x_o
);
  import rpq_pkg::*;

  vertex_t prev_q, first_q;
  logic    parity_q, parity_d;
  logic    have_up_q, have_up_d, have_right_q, have_right_d;
  coord_t  up_q, up_d, right_q, right_d;
  logic    edge_hit, up_hit, right_hit;

  function automatic logic crosses(vertex_t a, vertex_t b, coord_t px, coord_t py);
    logic span;
    span = (py < a.y && py > b.y) || (py > a.y && py < b.y);
    return (a.x == b.x) && (px >= a.x) && span;
  endfunction

  always_comb begin
    edge_hit = 1'b0;
    if (ctrl_i.rd_valid && !ctrl_i.rd_first) begin
      edge_hit = crosses(prev_q, vtx_i, px_i, py_i);
    end else if (ctrl_i.wrap) begin
      edge_hit = crosses(prev_q, first_q, px_i, py_i);
    end
    up_hit    = ctrl_i.rd_valid && (vtx_i.x == px_i) && (vtx_i.y > py_i) &&
                (!have_up_q || vtx_i.y < up_q);
    right_hit = ctrl_i.rd_valid && (vtx_i.y == py_i) && (vtx_i.x > px_i) &&
                (!have_right_q || vtx_i.x < right_q);

    parity_d     = parity_q ^ edge_hit;
    have_up_d    = have_up_q | up_hit;
    have_right_d = have_right_q | right_hit;
    up_d         = up_hit ? vtx_i.y : up_q;
    right_d      = right_hit ? vtx_i.x : right_q;
    if (ctrl_i.start) begin
      parity_d     = 1'b0;
      have_up_d    = 1'b0;
      have_right_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q     <= 1'b0;
      have_up_q    <= 1'b0;
      have_right_q <= 1'b0;
    end else begin
      parity_q     <= parity_d;
      have_up_q    <= have_up_d;
      have_right_q <= have_right_d;
    end
  end

  always_ff @(posedge clk_i) begin
    up_q    <= up_d;
    right_q <= right_d;
    if (ctrl_i.rd_valid) begin
      prev_q <= vtx_i;
      if (ctrl_i.rd_first) begin
        first_q <= vtx_i;
      end
    end
  end

  assign parity_o     = parity_q;
  assign have_up_o    = have_up_q;
  assign have_right_o = have_right_q;
  assign up_y_o       = up_q;
  assign right_x_o    = right_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rpq_checker.sv =====
// Port-level checker for the rectilinear polygon query block, bound to the top.
// Depends on rpq_pkg and rectilinear_polygon_query_defines.svh.
`default_nettype none

`include "rectilinear_polygon_query_defines.svh"

module rpq_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire rpq_pkg::rpq_in_t  in_item_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire rpq_pkg::rpq_out_t out_item_o
);
  import rpq_pkg::*;

  `RPQ_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o), "result item changed while stalled")
  `RPQ_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "input ready right after an item was taken")
  `RPQ_ASSERT_NOW(a_result_at_return, $rose(out_valid_o), in_ready_o && !$past(in_ready_o), "result appeared outside the return to idle")
  `RPQ_ASSERT_NOW(a_found_ok, out_valid_o && out_item_o.found, (out_item_o.status == ST_OK) && !out_item_o.inside_res, "found set on a result that is not a good rectangle query")

endmodule

bind rectilinear_polygon_query rpq_checker u_rpq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

// ===== bench/rectilinear_polygon_query_tb.sv =====
`timescale 1ns / 100ps
// Testbench for rectilinear_polygon_query: builds rectilinear polygons, runs inside and corner
// queries with random input gaps and output stalls, and checks each result against a tracker.
// Depends on rpq_pkg and the block's RTL only.

module rectilinear_polygon_query_tb;
  import rpq_pkg::*;

  localparam int unsigned MAX_VERTS = 64;
  localparam int unsigned ITEM_GOAL = 1300;
  localparam int unsigned CYCLE_CAP = 1_500_000;
  localparam int unsigned TAIL      = MAX_VERTS + 16;
  localparam coord_t      ONE       = coord_t'(32'h0001_0000);
  localparam coord_t      C_MIN     = coord_t'(32'h8000_0000);
  localparam coord_t      C_MAX     = coord_t'(32'h7fff_ffff);

  class polygon_tracker;
    coord_t      xs[MAX_VERTS];
    coord_t      ys[MAX_VERTS];
    int unsigned nverts;
    rpq_out_t    awaited_answers[$];
    int unsigned mismatches;

    function new();
      nverts     = 0;
      mismatches = 0;
    endfunction

    function bit point_inside(coord_t px, coord_t py);
      int unsigned i;
      int unsigned j;
      bit          odd;
      odd = 1'b0;
      for (i = 0; i < nverts; i++) begin
        j = (i + 1 == nverts) ? 0 : i + 1;
        if (xs[i] == xs[j] && px >= xs[i]) begin
          if ((py < ys[i] && py > ys[j]) || (py > ys[i] && py < ys[j])) odd = ~odd;
        end
      end
      return odd;
    endfunction

    function rpq_out_t predict_answer(rpq_in_t it);
      rpq_out_t    a;
      coord_t      px;
      coord_t      py;
      bit          have_up;
      bit          have_right;
      int unsigned i;
      px           = it.point_x;
      py           = it.point_y;
      a.status     = ST_OK;
      a.inside_res = 1'b0;
      a.found      = 1'b0;
      a.right_x    = px;
      a.up_y       = py;
      have_up      = 1'b0;
      have_right   = 1'b0;
      case (it.operation)
        OP_CLEAR: nverts = 0;
        OP_APPEND: begin
          if (nverts >= MAX_VERTS) begin
            a.status = ST_FULL;
          end else begin
            xs[nverts] = px;
            ys[nverts] = py;
            nverts++;
          end
        end
        default: begin
          if (nverts == 0) begin
            a.status = ST_EMPTY;
          end else if (it.operation == OP_INSIDE) begin
            a.inside_res = point_inside(px, py);
          end else begin
            for (i = 0; i < nverts; i++) begin
              if (xs[i] == px && ys[i] > py && (!have_up || ys[i] < coord_t'(a.up_y))) begin
                a.up_y  = ys[i];
                have_up = 1'b1;
              end
              if (ys[i] == py && xs[i] > px &&
                  (!have_right || xs[i] < coord_t'(a.right_x))) begin
                a.right_x  = xs[i];
                have_right = 1'b1;
              end
            end
            a.found = have_up && have_right;
          end
        end
      endcase
      return a;
    endfunction

    function void note_request(rpq_in_t it);
      awaited_answers.push_back(predict_answer(it));
    endfunction

    function void report(string tag, rpq_out_t want, rpq_out_t got);
      if (mismatches < 10) begin
        $display("%0t: %s: expected status %0d inside %0b found %0b right_x %h up_y %h",
                 $realtime, tag, want.status, want.inside_res, want.found, want.right_x,
                 want.up_y);
        $display("%0t: %s:   actual status %0d inside %0b found %0b right_x %h up_y %h",
                 $realtime, tag, got.status, got.inside_res, got.found, got.right_x,
                 got.up_y);
      end
      mismatches++;
    endfunction

    function void check_answer(rpq_out_t got);
      rpq_out_t want;
      if (awaited_answers.size() == 0) begin
        report("result with nothing outstanding", '0, got);
      end else begin
        want = awaited_answers.pop_front();
        if (got.status != want.status || got.inside_res != want.inside_res ||
            got.found != want.found || got.right_x != want.right_x || got.up_y != want.up_y)
          report("result mismatch", want, got);
      end
    endfunction

    function int unsigned failures();
      return mismatches + awaited_answers.size();
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  rpq_in_t     in_item_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  rpq_out_t    out_item_o;

  polygon_tracker board;
  bit             calm       = 1'b0;
  int unsigned    items_sent = 0;
  int unsigned    ready_hold = 0;
  coord_t         pool_x[6];
  coord_t         pool_y[6];

  rectilinear_polygon_query #(
    .MAX_VERTICES(MAX_VERTS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_CAP) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // grid points in Q16.16, some with fractions, plus extremes and raw words
  function automatic coord_t pick_base();
    case ($urandom_range(0, 9))
      0: return coord_t'($urandom);
      1: return C_MIN;
      2: return C_MAX;
      3: return coord_t'((int'($urandom_range(0, 24)) - 12) * 65536 +
                         int'($urandom_range(0, 65535)));
      default: return coord_t'((int'($urandom_range(0, 24)) - 12) * 65536);
    endcase
  endfunction

  function automatic coord_t near_to(coord_t c);
    case ($urandom_range(0, 9))
      6: return c + 1;
      7: return c - 1;
      8: return c + ONE / 2;
      9: return coord_t'($urandom);
      default: return c;
    endcase
  endfunction

  function automatic void fill_pool();
    int unsigned k;
    for (k = 0; k < 6; k++) begin
      pool_x[k] = pick_base();
      pool_y[k] = pick_base();
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_answer(out_item_o);
    if (calm || ready_hold == 0) begin
      out_ready_i <= 1'b1;
      ready_hold  <= pick_gap();
    end else begin
      out_ready_i <= 1'b0;
      ready_hold  <= ready_hold - 1;
    end
  end

  // valid stays high across back-to-back items; lowered for a gap and after the last item
  task automatic send_item(op_e op, coord_t x, coord_t y);
    int unsigned gap;
    rpq_in_t     it;
    gap          = pick_gap();
    it.operation = op;
    it.point_x   = x;
    it.point_y   = y;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(it);
    items_sent++;
  endtask

  task automatic send_query();
    send_item($urandom_range(0, 1) ? OP_INSIDE : OP_RECT,
              near_to(pool_x[$urandom_range(0, 5)]), near_to(pool_y[$urandom_range(0, 5)]));
  endtask

  // m corner pairs give 2m vertices with alternating horizontal and vertical edges
  task automatic build_polygon(int unsigned m);
    coord_t      cx[40];
    coord_t      cy[40];
    int unsigned k;
    for (k = 0; k < m; k++) begin
      cx[k] = ($urandom_range(0, 3) == 0) ? pick_base() : pool_x[$urandom_range(0, 5)];
      cy[k] = ($urandom_range(0, 3) == 0) ? pick_base() : pool_y[$urandom_range(0, 5)];
    end
    send_item(OP_CLEAR, pick_base(), pick_base());
    for (k = 0; k < m; k++) begin
      send_item(OP_APPEND, cx[k], cy[k]);
      send_item(OP_APPEND, cx[(k + 1) % m], cy[k]);
    end
  endtask

  initial begin
    int unsigned seq_no;
    int unsigned kind;
    int unsigned m;
    board = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty store
    send_item(OP_INSIDE, '0, '0);
    send_item(OP_RECT, C_MAX, C_MIN);
    // 4x4 square
    send_item(OP_CLEAR, C_MIN, C_MAX);
    send_item(OP_APPEND, '0, '0);
    send_item(OP_APPEND, 4 * ONE, '0);
    send_item(OP_APPEND, 4 * ONE, 4 * ONE);
    send_item(OP_APPEND, '0, 4 * ONE);
    send_item(OP_INSIDE, 2 * ONE, 2 * ONE);
    send_item(OP_INSIDE, 5 * ONE, 2 * ONE);
    send_item(OP_INSIDE, '0, 2 * ONE);
    send_item(OP_INSIDE, 2 * ONE, '0);
    send_item(OP_INSIDE, 4 * ONE, 2 * ONE);
    send_item(OP_RECT, '0, '0);
    send_item(OP_RECT, 4 * ONE, 4 * ONE);
    send_item(OP_RECT, '0, 4 * ONE);
    // full-range square
    send_item(OP_CLEAR, C_MAX, C_MIN);
    send_item(OP_APPEND, C_MIN, C_MIN);
    send_item(OP_APPEND, C_MAX, C_MIN);
    send_item(OP_APPEND, C_MAX, C_MAX);
    send_item(OP_APPEND, C_MIN, C_MAX);
    send_item(OP_INSIDE, '0, '0);
    send_item(OP_INSIDE, C_MAX, '0);
    send_item(OP_RECT, C_MIN, C_MIN);
    send_item(OP_RECT, C_MAX, C_MAX);

    seq_no = 0;
    while (items_sent < ITEM_GOAL) begin
      calm = ($urandom_range(0, 5) == 0);
      fill_pool();
      kind = (seq_no == 0) ? 0 : $urandom_range(0, 9);
      if (kind <= 6) begin
        if (seq_no == 0) m = MAX_VERTS / 2 + 1;
        else if ($urandom_range(0, 15) == 0) m = $urandom_range(MAX_VERTS / 2 - 2,
                                                                MAX_VERTS / 2 + 1);
        else m = $urandom_range(2, 6);
        build_polygon(m);
        repeat ($urandom_range(3, 10)) send_query();
      end else if (kind <= 8) begin
        repeat ($urandom_range(4, 12)) begin
          if ($urandom_range(0, 1)) send_item(op_e'($urandom_range(0, 3)), coord_t'($urandom),
                                              coord_t'($urandom));
          else send_item(op_e'($urandom_range(0, 3)), pick_base(), pick_base());
        end
      end else begin
        send_item(OP_CLEAR, pick_base(), pick_base());
        repeat ($urandom_range(0, 2))
          send_item(OP_APPEND, pool_x[$urandom_range(0, 5)], pool_y[$urandom_range(0, 5)]);
        repeat ($urandom_range(1, 4)) send_query();
      end
      seq_no++;
    end

    in_valid_i <= 1'b0;
    calm = 1'b0;
    while (board.awaited_answers.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
    if (board.failures() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
